>>> rtl/sspg_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Stepper step pulse generator package
// Shared widths, codes, command record and state types of the generator.
// ---------------------------------------------------------------------------
package sspg_pkg;

   localparam int SPEED_BITS        = 24;
   localparam int STEPS_PER_MM_BITS = 24;
   localparam int FIELD_POS_BITS    = 48;
   localparam int STEP_COUNT_BITS   = 48;
   localparam int HALF_BITS         = 19;
   localparam int TICK_BITS         = 19;
   localparam int PRODUCT_BITS      = SPEED_BITS + STEPS_PER_MM_BITS;
   localparam int MUL_SPLIT         = 12;
   localparam int RATE_FRAC_BITS    = 16;

   localparam int DEF_POSITION_BITS      = 48;
   localparam int DEF_MIN_HALF_PERIOD_US = 20;
   localparam int DEF_MAX_STEP_RATE      = 25000;

   localparam logic [63:0] HALF_SECOND_Q16 = 64'd500000 << RATE_FRAC_BITS;
   localparam logic [63:0] RATE_ONE_Q16    = 64'd1 << RATE_FRAC_BITS;
   localparam logic [63:0] DIV_INIT_REM    = HALF_SECOND_Q16 >> HALF_BITS;
   localparam logic [HALF_BITS-1:0] DIV_LOW_BITS = HALF_SECOND_Q16[HALF_BITS-1:0];

   localparam logic [HALF_BITS-1:0]         HALF_PERIOD_RESET  = 19'd20;
   localparam logic [STEPS_PER_MM_BITS-1:0] STEPS_PER_MM_RESET = 24'd20480;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic CSR_IDX_STEPS_PER_MM = 1'b0;
   localparam logic CSR_IDX_DIR_INVERTED = 1'b1;

   localparam logic signed [1:0] DIR_RIGHT = 2'sb01;
   localparam logic signed [1:0] DIR_LEFT  = 2'sb11;

   localparam int QUEUE_PTR_BITS = 1;
   localparam int QUEUE_DEPTH    = 1 << QUEUE_PTR_BITS;

   typedef enum logic [2:0] {
      OP_TICK        = 3'd0,
      OP_START       = 3'd1,
      OP_SET_SPEED   = 3'd2,
      OP_STOP        = 3'd3,
      OP_EMERGENCY   = 3'd4,
      OP_RIGHT_LIMIT = 3'd5,
      OP_SET_POS     = 3'd6
   } op_type;

   typedef struct packed {
      op_type                     op;
      logic signed [1:0]          move_dir;
      logic                       start_ok;
      logic                       rate_ok;
      logic [PRODUCT_BITS-1:0]    rate;
      logic signed [FIELD_POS_BITS-1:0] new_pos;
   } cmd_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_MUL_LO,
      FR_MUL_HI,
      FR_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_APPLY
   } back_state_type;

endpackage

>>> rtl/sspg_req_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Stepper command channel
// Valid/ready channel that carries one motor command per transfer.
// ---------------------------------------------------------------------------
interface sspg_req_if;
   import sspg_pkg::*;

   logic                             valid;
   logic                             ready;
   logic [2:0]                       opcode;
   logic signed [1:0]                move_direction;
   logic [SPEED_BITS-1:0]            speed_q8;
   logic signed [FIELD_POS_BITS-1:0] new_position;

   modport source (
      output valid, opcode, move_direction, speed_q8, new_position,
      input  ready
   );

   modport sink (
      input  valid, opcode, move_direction, speed_q8, new_position,
      output ready
   );
endinterface

>>> rtl/sspg_rsp_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Stepper status channel
// Valid/ready channel that carries the pin and counter status per command.
// ---------------------------------------------------------------------------
interface sspg_rsp_if;
   import sspg_pkg::*;

   logic                             valid;
   logic                             ready;
   logic                             accepted;
   logic                             step_level;
   logic                             dir_level;
   logic                             is_moving;
   logic signed [FIELD_POS_BITS-1:0] position;
   logic [STEP_COUNT_BITS-1:0]       steps_done;

   modport source (
      output valid, accepted, step_level, dir_level, is_moving, position, steps_done,
      input  ready
   );

   modport sink (
      input  valid, accepted, step_level, dir_level, is_moving, position, steps_done,
      output ready
   );
endinterface

>>> rtl/sspg_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Stepper command front end
// Takes commands, validates starts and forms the Q16 step rate in two passes
// of a 24x12 multiplier before handing the command to the queue.
// ---------------------------------------------------------------------------
module sspg_front #(
   parameter int MAX_STEP_RATE = sspg_pkg::DEF_MAX_STEP_RATE
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [sspg_pkg::STEPS_PER_MM_BITS-1:0] steps_per_mm_q8,
   sspg_req_if.sink                               req_chan,
   output logic                                   push_valid,
   output sspg_pkg::cmd_type                      push_cmd,
   input  logic                                   queue_full
);
   import sspg_pkg::*;

   localparam logic [PRODUCT_BITS-1:0] RATE_MAX_Q16 =
      PRODUCT_BITS'(64'(MAX_STEP_RATE) << RATE_FRAC_BITS);
   localparam logic [PRODUCT_BITS-1:0] RATE_MIN_Q16 = PRODUCT_BITS'(RATE_ONE_Q16);
   localparam int PART_BITS = STEPS_PER_MM_BITS + MUL_SPLIT;

   front_state_type         state_ff, state_in;
   cmd_type                 cmd_ff, cmd_in;
   logic [SPEED_BITS-1:0]   speed_ff, speed_in;
   logic [PRODUCT_BITS-1:0] acc_ff, acc_in;
   logic [MUL_SPLIT-1:0]    mul_digit;
   logic [PART_BITS-1:0]    partial;
   logic                    req_take;
   logic [2:0]              op_bits;

   assign op_bits   = req_chan.opcode;
   assign req_take  = req_chan.valid && req_chan.ready;
   assign mul_digit = (state_ff == FR_MUL_LO) ? speed_ff[MUL_SPLIT-1:0]
                                              : speed_ff[SPEED_BITS-1:MUL_SPLIT];
   assign partial   = PART_BITS'(steps_per_mm_q8) * PART_BITS'(mul_digit);

   always_comb begin
      state_in         = state_ff;
      cmd_in           = cmd_ff;
      speed_in         = speed_ff;
      acc_in           = acc_ff;
      req_chan.ready   = 1'b0;
      push_valid       = 1'b0;
      push_cmd         = cmd_ff;
      push_cmd.rate    = acc_ff;
      push_cmd.rate_ok = (acc_ff >= RATE_MIN_Q16) && (acc_ff <= RATE_MAX_Q16);
      unique case (state_ff)
         FR_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_take) begin
               cmd_in.op       = op_type'(op_bits);
               cmd_in.move_dir = req_chan.move_direction;
               cmd_in.new_pos  = req_chan.new_position;
               cmd_in.start_ok = ((req_chan.move_direction == DIR_RIGHT) ||
                                  (req_chan.move_direction == DIR_LEFT)) &&
                                 (req_chan.speed_q8 != '0);
               cmd_in.rate_ok  = 1'b0;
               cmd_in.rate     = '0;
               speed_in        = req_chan.speed_q8;
               if ((op_type'(op_bits) == OP_START) || (op_type'(op_bits) == OP_SET_SPEED)) begin
                  state_in = FR_MUL_LO;
               end else begin
                  state_in = FR_PUSH;
               end
            end
         end
         FR_MUL_LO: begin
            acc_in   = PRODUCT_BITS'(partial);
            state_in = FR_MUL_HI;
         end
         FR_MUL_HI: begin
            acc_in   = acc_ff + (PRODUCT_BITS'(partial) << MUL_SPLIT);
            state_in = FR_PUSH;
         end
         FR_PUSH: begin
            if (!queue_full) begin
               push_valid = 1'b1;
               state_in   = FR_IDLE;
            end
         end
         default: state_in = FR_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      speed_ff <= speed_in;
      acc_ff   <= acc_in;
   end

endmodule

>>> rtl/sspg_cmd_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Stepper command queue
// Two-entry FIFO that decouples the command front end from the pulse engine.
// ---------------------------------------------------------------------------
module sspg_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sspg_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output sspg_pkg::cmd_type pop_cmd,
   output logic              empty
);
   import sspg_pkg::*;

   cmd_type                   entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;
   logic                      do_push;
   logic                      do_pop;

   assign full    = (count_ff == (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> rtl/sspg_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Stepper pulse engine
// Executes queued commands: derives the half period with a restoring
// divider, keeps the STEP/DIR state and counters, and holds the status
// output register.
// ---------------------------------------------------------------------------
module sspg_back #(
   parameter int POSITION_BITS      = sspg_pkg::DEF_POSITION_BITS,
   parameter int MIN_HALF_PERIOD_US = sspg_pkg::DEF_MIN_HALF_PERIOD_US,
   parameter int MAX_STEP_RATE      = sspg_pkg::DEF_MAX_STEP_RATE
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              direction_inverted,
   input  sspg_pkg::cmd_type pop_cmd,
   input  logic              queue_empty,
   output logic              pop,
   sspg_rsp_if.source        rsp_chan
);
   import sspg_pkg::*;

   localparam int RATE_BITS = $clog2((64'(MAX_STEP_RATE) << RATE_FRAC_BITS) + 64'd1);
   localparam int CNT_BITS  = $clog2(HALF_BITS);
   localparam logic [CNT_BITS-1:0]  DIV_LAST = CNT_BITS'(HALF_BITS - 1);
   localparam logic [HALF_BITS-1:0] HALF_MIN = HALF_BITS'(MIN_HALF_PERIOD_US);

   back_state_type             state_ff, state_in;
   cmd_type                    cmd_ff, cmd_in;
   logic [RATE_BITS-1:0]       rem_ff, rem_in;
   logic [HALF_BITS-1:0]       quo_ff, quo_in;
   logic [HALF_BITS-1:0]       lo_ff, lo_in;
   logic [CNT_BITS-1:0]        cnt_ff, cnt_in;

   logic                       moving_ff, moving_in;
   logic                       step_high_ff, step_high_in;
   logic signed [1:0]          direction_ff, direction_in;
   logic                       dir_pin_ff, dir_pin_in;
   logic [HALF_BITS-1:0]       half_ff, half_in;
   logic [TICK_BITS-1:0]       tick_ff, tick_in;
   logic [POSITION_BITS-1:0]   pos_ff, pos_in;
   logic [STEP_COUNT_BITS-1:0] steps_ff, steps_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       accepted_ff, accepted_in;

   logic [RATE_BITS-1:0]       rate;
   logic [RATE_BITS:0]         trial;
   logic                       trial_ge;
   logic [HALF_BITS-1:0]       half_new;
   logic [TICK_BITS-1:0]       tick_next;
   logic                       needs_div;

   assign rate      = cmd_ff.rate[RATE_BITS-1:0];
   assign trial     = {rem_ff, lo_ff[HALF_BITS-1]};
   assign trial_ge  = (trial >= {1'b0, rate});
   assign half_new  = (quo_ff < HALF_MIN) ? HALF_MIN : quo_ff;
   assign tick_next = tick_ff + 1'b1;
   assign needs_div = pop_cmd.rate_ok &&
                      (((pop_cmd.op == OP_START) && pop_cmd.start_ok) ||
                       (pop_cmd.op == OP_SET_SPEED));

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      lo_in        = lo_ff;
      cnt_in       = cnt_ff;
      moving_in    = moving_ff;
      step_high_in = step_high_ff;
      direction_in = direction_ff;
      dir_pin_in   = dir_pin_ff;
      half_in      = half_ff;
      tick_in      = tick_ff;
      pos_in       = pos_ff;
      steps_in     = steps_ff;
      accepted_in  = accepted_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      pop          = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!queue_empty) begin
               pop      = 1'b1;
               cmd_in   = pop_cmd;
               rem_in   = RATE_BITS'(DIV_INIT_REM);
               quo_in   = '0;
               lo_in    = DIV_LOW_BITS;
               cnt_in   = '0;
               state_in = needs_div ? BK_DIV : BK_APPLY;
            end
         end
         BK_DIV: begin
            rem_in = trial_ge ? RATE_BITS'(trial - {1'b0, rate}) : trial[RATE_BITS-1:0];
            quo_in = {quo_ff[HALF_BITS-2:0], trial_ge};
            lo_in  = lo_ff << 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = BK_APPLY;
            end
         end
         BK_APPLY: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               accepted_in  = 1'b0;
               state_in     = BK_IDLE;
               unique case (cmd_ff.op)
                  OP_TICK: begin
                     if (moving_ff) begin
                        if (tick_next >= half_ff) begin
                           tick_in      = '0;
                           step_high_in = !step_high_ff;
                           if (!step_high_ff) begin
                              pos_in   = pos_ff + POSITION_BITS'(direction_ff);
                              steps_in = steps_ff + 1'b1;
                           end
                        end else begin
                           tick_in = tick_next;
                        end
                     end
                  end
                  OP_START: begin
                     if (cmd_ff.start_ok) begin
                        moving_in    = 1'b0;
                        step_high_in = 1'b0;
                        direction_in = '0;
                        dir_pin_in   = (cmd_ff.move_dir == DIR_RIGHT) ^ direction_inverted;
                        if (cmd_ff.rate_ok) begin
                           half_in      = half_new;
                           tick_in      = '0;
                           direction_in = cmd_ff.move_dir;
                           steps_in     = '0;
                           moving_in    = 1'b1;
                           accepted_in  = 1'b1;
                        end
                     end
                  end
                  OP_SET_SPEED: begin
                     if (moving_ff && cmd_ff.rate_ok) begin
                        half_in     = half_new;
                        accepted_in = 1'b1;
                     end
                  end
                  OP_STOP, OP_EMERGENCY: begin
                     moving_in    = 1'b0;
                     step_high_in = 1'b0;
                     direction_in = '0;
                  end
                  OP_RIGHT_LIMIT: begin
                     if (direction_ff == DIR_RIGHT) begin
                        moving_in    = 1'b0;
                        step_high_in = 1'b0;
                        direction_in = '0;
                     end
                  end
                  OP_SET_POS: begin
                     pos_in = POSITION_BITS'(cmd_ff.new_pos);
                  end
                  default: begin
                     accepted_in = 1'b0;
                  end
               endcase
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         moving_ff    <= 1'b0;
         step_high_ff <= 1'b0;
         direction_ff <= '0;
         dir_pin_ff   <= 1'b0;
         half_ff      <= HALF_PERIOD_RESET;
         tick_ff      <= '0;
         pos_ff       <= '0;
         steps_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         moving_ff    <= moving_in;
         step_high_ff <= step_high_in;
         direction_ff <= direction_in;
         dir_pin_ff   <= dir_pin_in;
         half_ff      <= half_in;
         tick_ff      <= tick_in;
         pos_ff       <= pos_in;
         steps_ff     <= steps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      lo_ff       <= lo_in;
      cnt_ff      <= cnt_in;
      accepted_ff <= accepted_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.accepted   = accepted_ff;
   assign rsp_chan.step_level = step_high_ff;
   assign rsp_chan.dir_level  = dir_pin_ff;
   assign rsp_chan.is_moving  = moving_ff;
   assign rsp_chan.position   = FIELD_POS_BITS'(pos_ff);
   assign rsp_chan.steps_done = steps_ff;

endmodule

>>> rtl/stepper_step_pulse_generator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Stepper step pulse generator
// STEP/DIR generator driven by 1 us tick commands and motion commands.
// ---------------------------------------------------------------------------
// Commands enter on req_chan and every command yields exactly one status
// transfer on rsp_chan, in order, reporting the pin levels, the moving flag,
// the position and the steps since the last accepted start.
// The front end takes a new command only once it has pushed the last one to
// the queue; start and speed-change commands first pass the low and high
// multiplier states. The pulse engine pops a command when idle and applies
// it in the apply state; a start or speed change whose rate is in range
// first runs a 19-step restoring divider for the half period. A two-entry
// queue lets the front end keep accepting while the engine divides.
// If the receiver stalls, the status register holds and the engine waits;
// the queue then fills and req_chan.ready drops.
// The APB-style csr port holds the steps-per-mm and direction-inversion
// registers at byte addresses 0 and 4; write them only while idle.
// Reset is synchronous and returns the motor to idle at position zero.
// ---------------------------------------------------------------------------
module stepper_step_pulse_generator #(
   parameter int POSITION_BITS      = sspg_pkg::DEF_POSITION_BITS,
   parameter int MIN_HALF_PERIOD_US = sspg_pkg::DEF_MIN_HALF_PERIOD_US,
   parameter int MAX_STEP_RATE      = sspg_pkg::DEF_MAX_STEP_RATE
) (
   input  logic                               clock,
   input  logic                               reset,
   sspg_req_if.sink                           req_chan,
   sspg_rsp_if.source                         rsp_chan,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [sspg_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [sspg_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [sspg_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready
);
   import sspg_pkg::*;

   logic [STEPS_PER_MM_BITS-1:0] steps_per_mm_ff, steps_per_mm_in;
   logic                         dir_inv_ff, dir_inv_in;
   logic                         csr_write;
   logic                         csr_index;
   logic                         push_valid;
   cmd_type                      push_cmd;
   logic                         queue_full;
   logic                         pop;
   cmd_type                      pop_cmd;
   logic                         queue_empty;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[2];

   always_comb begin
      steps_per_mm_in = steps_per_mm_ff;
      dir_inv_in      = dir_inv_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_IDX_STEPS_PER_MM: steps_per_mm_in = csr_pwdata[STEPS_PER_MM_BITS-1:0];
            CSR_IDX_DIR_INVERTED: dir_inv_in      = csr_pwdata[0];
            default: dir_inv_in = dir_inv_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_IDX_STEPS_PER_MM: csr_prdata = CSR_DATA_BITS'(steps_per_mm_ff);
         CSR_IDX_DIR_INVERTED: csr_prdata = CSR_DATA_BITS'(dir_inv_ff);
         default:              csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_per_mm_ff <= STEPS_PER_MM_RESET;
         dir_inv_ff      <= 1'b0;
      end else begin
         steps_per_mm_ff <= steps_per_mm_in;
         dir_inv_ff      <= dir_inv_in;
      end
   end

   sspg_front #(
      .MAX_STEP_RATE (MAX_STEP_RATE)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .steps_per_mm_q8 (steps_per_mm_ff),
      .req_chan        (req_chan),
      .push_valid      (push_valid),
      .push_cmd        (push_cmd),
      .queue_full      (queue_full)
   );

   sspg_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push_valid),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .empty    (queue_empty)
   );

   sspg_back #(
      .POSITION_BITS      (POSITION_BITS),
      .MIN_HALF_PERIOD_US (MIN_HALF_PERIOD_US),
      .MAX_STEP_RATE      (MAX_STEP_RATE)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .direction_inverted (dir_inv_ff),
      .pop_cmd            (pop_cmd),
      .queue_empty        (queue_empty),
      .pop                (pop),
      .rsp_chan           (rsp_chan)
   );

endmodule

>>> tb/sspg_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Stepper pulse generator status checker
// Watches the command, status and register ports, keeps its own copy of the
// motor state, predicts the status of every command and compares it field by
// field with what the generator returns, in order.
// ---------------------------------------------------------------------------
module sspg_checker (
   input  logic                               clock,
   input  logic                               reset,
   sspg_req_if                                req_mon,
   sspg_rsp_if                                rsp_mon,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic                               csr_pready,
   input  logic [sspg_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [sspg_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output int                                 fail_count,
   output int                                 pending,
   output int                                 checked,
   output int                                 taken,
   output int                                 pulses
);
   import sspg_pkg::*;

   localparam logic signed [1:0] DIR_NONE = 2'sb00;
   localparam int MISMATCH_SHOWN = 10;

   typedef struct packed {
      logic        accepted;
      logic        step_level;
      logic        dir_level;
      logic        is_moving;
      logic [47:0] position;
      logic [47:0] steps_done;
   } motor_status_type;

   motor_status_type status_due[$];

   logic [STEPS_PER_MM_BITS-1:0] steps_per_mm;
   logic                         inverted;
   logic                         running;
   logic                         step_hi;
   logic signed [1:0]            heading;
   logic                         dir_pin;
   logic [HALF_BITS-1:0]         half;
   logic [TICK_BITS-1:0]         ticks;
   logic [47:0]                  pos;
   logic [47:0]                  steps;

   // Zero means the step rate is out of range.
   function automatic logic [HALF_BITS-1:0] half_period_for(input logic [23:0] speed);
      logic [47:0] rate;
      logic [63:0] quotient;
      rate = speed * steps_per_mm;
      if (rate < 48'(RATE_ONE_Q16)
          || rate > (48'(DEF_MAX_STEP_RATE) << RATE_FRAC_BITS)) begin
         return '0;
      end
      quotient = HALF_SECOND_Q16 / 64'(rate);
      if (quotient < 64'(DEF_MIN_HALF_PERIOD_US)) begin
         quotient = 64'(DEF_MIN_HALF_PERIOD_US);
      end
      return quotient[HALF_BITS-1:0];
   endfunction

   task automatic halt_motor();
      running = 1'b0;
      step_hi = 1'b0;
      heading = DIR_NONE;
   endtask

   task automatic apply_command(output logic took);
      logic signed [1:0]    asked;
      logic [HALF_BITS-1:0] h;
      took = 1'b0;
      asked = (req_mon.move_direction == DIR_RIGHT || req_mon.move_direction == DIR_LEFT)
              ? req_mon.move_direction : DIR_NONE;
      case (req_mon.opcode)
         OP_TICK: begin
            if (running) begin
               ticks = ticks + 1'b1;
               if (ticks >= half) begin
                  ticks = '0;
                  step_hi = !step_hi;
                  if (step_hi) begin
                     pos = pos + {{46{heading[1]}}, heading};
                     steps = steps + 1'b1;
                     pulses++;
                  end
               end
            end
         end
         OP_START: begin
            if (asked != DIR_NONE && req_mon.speed_q8 != '0) begin
               halt_motor();
               dir_pin = (asked == DIR_RIGHT) ^ inverted;
               h = half_period_for(req_mon.speed_q8);
               if (h != '0) begin
                  half = h;
                  ticks = '0;
                  heading = asked;
                  steps = '0;
                  running = 1'b1;
                  took = 1'b1;
               end
            end
         end
         OP_SET_SPEED: begin
            if (running) begin
               h = half_period_for(req_mon.speed_q8);
               if (h != '0) begin
                  half = h;
                  took = 1'b1;
               end
            end
         end
         OP_STOP, OP_EMERGENCY: begin
            halt_motor();
         end
         OP_RIGHT_LIMIT: begin
            if (heading == DIR_RIGHT) begin
               halt_motor();
            end
         end
         OP_SET_POS: begin
            pos = req_mon.new_position;
         end
         default: begin
         end
      endcase
   endtask

   task automatic flag(input string what, input logic [47:0] want, input logic [47:0] got);
      fail_count++;
      if (fail_count <= MISMATCH_SHOWN) begin
         $display("Mismatch in %s at status %0d: expected %h, got %h",
                  what, checked, want, got);
      end
   endtask

   always @(posedge clock) begin
      logic             took;
      motor_status_type want;
      if (reset) begin
         steps_per_mm = STEPS_PER_MM_RESET;
         inverted = 1'b0;
         running = 1'b0;
         step_hi = 1'b0;
         heading = DIR_NONE;
         dir_pin = 1'b0;
         half = HALF_PERIOD_RESET;
         ticks = '0;
         pos = '0;
         steps = '0;
         status_due.delete();
         fail_count = 0;
         checked = 0;
         taken = 0;
         pulses = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == {CSR_IDX_STEPS_PER_MM, 2'b00}) begin
               steps_per_mm = csr_pwdata[STEPS_PER_MM_BITS-1:0];
            end else if (csr_paddr == {CSR_IDX_DIR_INVERTED, 2'b00}) begin
               inverted = csr_pwdata[0];
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            apply_command(took);
            if (took) begin
               taken++;
            end
            status_due.push_back('{took, step_hi, dir_pin, running, pos, steps});
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (status_due.size() == 0) begin
               flag("status with nothing pending", '0, rsp_mon.position);
            end else begin
               want = status_due.pop_front();
               if (want.accepted !== rsp_mon.accepted) begin
                  flag("accepted", 48'(want.accepted), 48'(rsp_mon.accepted));
               end
               if (want.step_level !== rsp_mon.step_level) begin
                  flag("step_level", 48'(want.step_level), 48'(rsp_mon.step_level));
               end
               if (want.dir_level !== rsp_mon.dir_level) begin
                  flag("dir_level", 48'(want.dir_level), 48'(rsp_mon.dir_level));
               end
               if (want.is_moving !== rsp_mon.is_moving) begin
                  flag("is_moving", 48'(want.is_moving), 48'(rsp_mon.is_moving));
               end
               if (want.position !== rsp_mon.position) begin
                  flag("position", want.position, rsp_mon.position);
               end
               if (want.steps_done !== rsp_mon.steps_done) begin
                  flag("steps_done", want.steps_done, rsp_mon.steps_done);
               end
            end
            checked++;
         end
      end
      pending = status_due.size();
   end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Stepper pulse generator testbench
// Drives directed and random motion commands through several register
// settings and idle patterns; a separate checker predicts every status.
// ---------------------------------------------------------------------------
module testbench;
   import sspg_pkg::*;

   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASES        = 5;
   localparam logic [CSR_ADDR_BITS-1:0] ADDR_STEPS_PER_MM = {CSR_IDX_STEPS_PER_MM, 2'b00};
   localparam logic [CSR_ADDR_BITS-1:0] ADDR_DIR_INVERTED = {CSR_IDX_DIR_INVERTED, 2'b00};
   localparam logic [47:0] POS_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] POS_MIN = 48'h8000_0000_0000;
   localparam logic [2:0]  OP_UNUSED = 3'd7;
   localparam logic [1:0]  DIR_NONE  = 2'b00;
   localparam logic [1:0]  DIR_BAD   = 2'b10;

   logic                     clock;
   logic                     reset;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   int send_idle = 0;
   int take_idle = 0;
   int sent = 0;
   int stall = 0;
   int fail_count;
   int pending;
   int checked;
   int taken;
   int pulses;
   logic [STEPS_PER_MM_BITS-1:0] cur_spm;

   sspg_req_if req_chan();
   sspg_rsp_if rsp_chan();

   stepper_step_pulse_generator u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   sspg_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_pready  (csr_pready),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .fail_count  (fail_count),
      .pending     (pending),
      .checked     (checked),
      .taken       (taken),
      .pulses      (pulses)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= take_idle);
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || csr_psel) begin
         stall <= 0;
      end else if (stall >= STALL_LIMIT) begin
         $display("Timeout after %0d cycles without a transfer", STALL_LIMIT);
         $display("FAILURE");
         $finish;
      end else begin
         stall <= stall + 1;
      end
   end

   function automatic logic [23:0] speed_for(input int unsigned steps_per_s);
      logic [63:0] q;
      if (cur_spm == '0) begin
         return 24'($urandom);
      end
      q = (64'(steps_per_s) << RATE_FRAC_BITS) / 64'(cur_spm);
      if (q == 0) begin
         q = 1;
      end else if (q > 64'hFF_FFFF) begin
         q = 64'hFF_FFFF;
      end
      return q[23:0];
   endfunction

   // Mostly fast rates, so that pulses come within a session.
   function automatic int unsigned some_rate();
      int r;
      r = $urandom_range(99);
      if (r < 60) begin
         return $urandom_range(20000, 25000);
      end else if (r < 85) begin
         return $urandom_range(1000, 25000);
      end
      return $urandom_range(1, 40000);
   endfunction

   function automatic logic [1:0] some_dir();
      return $urandom_range(1) ? DIR_RIGHT : DIR_LEFT;
   endfunction

   function automatic logic [47:0] some_position();
      if ($urandom_range(1)) begin
         return 48'({$urandom, $urandom});
      end else if ($urandom_range(1)) begin
         return POS_MAX - 48'($urandom_range(3));
      end
      return POS_MIN + 48'($urandom_range(3));
   endfunction

   task automatic send_item(input logic [2:0] op, input logic [1:0] dir,
                            input logic [23:0] speed, input logic [47:0] npos);
      if (sent < 250) begin
         send_idle = 24;
         take_idle = 74;
      end else if (sent < 500) begin
         send_idle = 74;
         take_idle = 24;
      end else begin
         send_idle = 0;
         take_idle = 0;
      end
      while ($urandom_range(99) < send_idle) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.opcode = op;
      req_chan.move_direction = dir;
      req_chan.speed_q8 = speed;
      req_chan.new_position = npos;
      req_chan.valid = 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      sent++;
   endtask

   task automatic send_plain(input logic [2:0] op);
      send_item(op, 2'($urandom), 24'($urandom), 48'({$urandom, $urandom}));
   endtask

   task automatic csr_write(input logic [CSR_ADDR_BITS-1:0] addr,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_penable = 1'b0;
      csr_paddr = addr;
      csr_pwdata = data;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   task automatic drain();
      req_chan.valid = 1'b0;
      while (pending != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic directed();
      send_item(OP_START, DIR_NONE, 24'd80000, '0);
      send_item(OP_START, DIR_BAD, 24'd80000, '0);
      send_item(OP_START, DIR_RIGHT, 24'd0, '0);
      send_item(OP_SET_SPEED, DIR_NONE, 24'd80000, '0);
      send_plain(OP_TICK);
      send_item(OP_UNUSED, DIR_RIGHT, 24'hFF_FFFF, POS_MAX);
      send_item(OP_SET_POS, DIR_NONE, '0, POS_MAX);
      send_item(OP_START, DIR_RIGHT, 24'hFF_FFFF, '0);
      send_item(OP_START, DIR_LEFT, 24'd1, '0);
      send_item(OP_START, DIR_RIGHT, 24'd80000, '0);
      send_item(OP_SET_SPEED, DIR_NONE, 24'hFF_FFFF, '0);
      send_item(OP_SET_SPEED, DIR_NONE, 24'd256, '0);
      send_plain(OP_TICK);
      send_plain(OP_RIGHT_LIMIT);
      send_item(OP_START, DIR_LEFT, 24'd80000, '0);
      send_plain(OP_RIGHT_LIMIT);
      send_plain(OP_TICK);
      send_plain(OP_STOP);
      send_item(OP_START, DIR_RIGHT, 24'd80000, '0);
      send_plain(OP_EMERGENCY);
      send_item(OP_SET_POS, DIR_NONE, '0, POS_MIN);
      send_item(OP_SET_POS, DIR_NONE, '0, 48'h0);
   endtask

   // A start, a run of ticks with occasional commands mixed in, and often a stop.
   task automatic run_session();
      int n;
      int r;
      if ($urandom_range(4) == 0) begin
         send_item(OP_SET_POS, 2'($urandom), 24'($urandom), some_position());
      end
      send_item(OP_START, some_dir(), speed_for(some_rate()), 48'({$urandom, $urandom}));
      n = $urandom_range(20, 90);
      repeat (n) begin
         r = $urandom_range(99);
         if (r < 85) begin
            send_plain(OP_TICK);
         end else if (r < 90) begin
            send_item(OP_SET_SPEED, 2'($urandom), speed_for(some_rate()),
                      48'({$urandom, $urandom}));
         end else if (r < 93) begin
            send_item(OP_SET_POS, 2'($urandom), 24'($urandom), some_position());
         end else if (r < 96) begin
            send_plain(OP_RIGHT_LIMIT);
         end else if (r < 98) begin
            send_plain($urandom_range(1) ? OP_STOP : OP_EMERGENCY);
         end else begin
            send_plain(3'($urandom_range(7)));
         end
      end
      if ($urandom_range(1)) begin
         send_plain(3'($urandom_range(OP_STOP, OP_RIGHT_LIMIT)));
      end
   endtask

   task automatic run_random(input int n);
      int target;
      target = sent + n;
      while (sent < target) begin
         if ($urandom_range(99) < 70) begin
            run_session();
         end else begin
            send_plain(3'($urandom_range(7)));
         end
      end
   endtask

   initial begin
      logic [STEPS_PER_MM_BITS-1:0] spm_set[PHASES];
      logic                         inv_set[PHASES];
      int                           count_set[PHASES];
      spm_set = '{24'd20480, 24'hFF_FFFF, 24'd0, 24'd256, 24'd0};
      inv_set = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
      count_set = '{200, 170, 40, 170, 170};
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      cur_spm = STEPS_PER_MM_RESET;
      req_chan.valid = 1'b0;
      req_chan.opcode = '0;
      req_chan.move_direction = '0;
      req_chan.speed_q8 = '0;
      req_chan.new_position = '0;
      rsp_chan.ready = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      for (int p = 0; p < PHASES; p++) begin
         drain();
         if (p == PHASES - 1) begin
            spm_set[p] = 24'($urandom_range(1000, 100000));
            inv_set[p] = 1'($urandom_range(1));
         end
         cur_spm = spm_set[p];
         csr_write(ADDR_STEPS_PER_MM, CSR_DATA_BITS'(spm_set[p]));
         csr_write(ADDR_DIR_INVERTED, CSR_DATA_BITS'(inv_set[p]));
         if (p == 0) begin
            directed();
         end
         run_random(count_set[p]);
      end
      drain();
      $display("Sent %0d commands over %0d register settings and three idle patterns.",
               sent, PHASES);
      $display("Checked %0d statuses: %0d starts or speed changes taken, %0d step pulses,",
               checked, taken, pulses);
      $display("and found %0d mismatches.", fail_count);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
